/* rtl/rpc_pkg.sv */
`default_nettype none
// rpc_pkg: widths, config register indexes, sideband types and the sine table
// shared by the radar point rotate/clamp block. No dependencies.
package rpc_pkg;

    // field widths
    localparam int COORD_W    = 24;
    localparam int HEAD_W     = 16;
    localparam int CEN_W      = 12;
    localparam int RADIUS_W   = 10;
    localparam int OUT_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // internal datapath widths, sized for the worst case fraction setting
    localparam int DIFF_W = COORD_W + 1;
    localparam int TRIG_W = 17;
    localparam int PROD_W = DIFF_W + TRIG_W;
    localparam int SUM_W  = 45;
    localparam int PIX_W  = 28;
    localparam int MAG_W  = 27;
    localparam int D2_W   = 52;
    localparam int NUM_W  = MAG_W + RADIUS_W + 6;
    localparam int DIST_FRAC2 = 12;
    localparam int ISQ_W  = D2_W + DIST_FRAC2;
    localparam int ROOT_W = ISQ_W / 2;

    localparam logic [15:0] QUARTER_TURN = 16'h4000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OBSERVER_X   = 3'd0,
        CFG_OBSERVER_Z   = 3'd1,
        CFG_HEADING      = 3'd2,
        CFG_MAP_CENTER_X = 3'd3,
        CFG_MAP_CENTER_Y = 3'd4,
        CFG_MAP_RADIUS   = 3'd5
    } cfg_index_t;

    // sideband that rides along the square root pipe
    typedef struct packed {
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        logic                    neg_x;
        logic                    neg_y;
        logic                    clamp;
        logic [NUM_W-1:0]        num_x;
        logic [NUM_W-1:0]        num_y;
    } sq_side_t;

    // sideband that rides along the divider pipe
    typedef struct packed {
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        logic                    neg_x;
        logic                    neg_y;
        logic                    clamp;
    } dv_side_t;

    function automatic logic [14:0] quarter_sine(input logic [4:0] idx);
        logic [14:0] v;
        unique case (idx)
            5'd0:    v = 15'd0;
            5'd1:    v = 15'd3212;
            5'd2:    v = 15'd6393;
            5'd3:    v = 15'd9512;
            5'd4:    v = 15'd12539;
            5'd5:    v = 15'd15446;
            5'd6:    v = 15'd18204;
            5'd7:    v = 15'd20787;
            5'd8:    v = 15'd23170;
            5'd9:    v = 15'd25329;
            5'd10:   v = 15'd27245;
            5'd11:   v = 15'd28898;
            5'd12:   v = 15'd30273;
            5'd13:   v = 15'd31356;
            5'd14:   v = 15'd32137;
            5'd15:   v = 15'd32609;
            5'd16:   v = 15'd32767;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // Q1.15 sine of a 16 bit binary angle, linear interpolation, floored
    function automatic logic signed [TRIG_W-1:0] sine_q15(input logic [15:0] a);
        logic [1:0]  quad;
        logic [14:0] w;
        logic [4:0]  i;
        logic [9:0]  f;
        logic [14:0] base;
        logic [14:0] nxt;
        logic [21:0] prod;
        logic [14:0] m;
        quad = a[15:14];
        w    = {1'b0, a[13:0]};
        if (quad[0])
            w = 15'd16384 - w;
        i    = w[14:10];
        f    = w[9:0];
        base = quarter_sine(i);
        nxt  = quarter_sine(i + 5'd1);
        prod = 22'(nxt - base) * 22'(f);
        if (i >= 5'd16)
            m = quarter_sine(5'd16);
        else
            m = base + 15'(prod >> 10);
        return quad[1] ? -$signed(TRIG_W'(m)) : $signed(TRIG_W'(m));
    endfunction

endpackage
`default_nettype wire

/* rtl/rpc_if.sv */
`default_nettype none
// Channel interfaces of the radar point block: point in, pixel out, config write.
// Depends on rpc_pkg for field widths.
interface rpc_in_if;
    import rpc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_z;
    modport source (output valid, output target_x, output target_z, input ready);
    modport sink   (input valid, input target_x, input target_z, output ready);
endinterface

interface rpc_out_if;
    import rpc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] screen_x;
    logic signed [OUT_W-1:0] screen_y;
    logic                    was_clamped;
    modport source (output valid, output screen_x, output screen_y, output was_clamped,
                    input ready);
    modport sink   (input valid, input screen_x, input screen_y, input was_clamped,
                    output ready);
endinterface

interface rpc_cfg_if;
    import rpc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/rpc_isqrt.sv */
`default_nettype none
// rpc_isqrt: pipelined floor square root, one result bit per stage, with sideband.
// Standalone; no package dependency.
module rpc_isqrt #(
    parameter int RAD_W  = 64,
    parameter int SIDE_W = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_vld,
    input  wire logic [RAD_W-1:0]     rad,
    input  wire logic [SIDE_W-1:0]    side_in,
    output logic                      out_vld,
    output logic [RAD_W/2-1:0]        root,
    output logic [SIDE_W-1:0]         side_out
);
    localparam int RT_W  = RAD_W / 2;
    localparam int REM_W = RT_W + 2;

    logic              vld_reg  [RT_W];
    logic [RAD_W-1:0]  rad_reg  [RT_W];
    logic [REM_W-1:0]  rem_reg  [RT_W];
    logic [RT_W-1:0]   root_reg [RT_W];
    logic [SIDE_W-1:0] side_reg [RT_W];

    for (genvar s = 0; s < RT_W; s++) begin : g_stage
        logic              vld_q;
        logic [RAD_W-1:0]  rad_q;
        logic [REM_W-1:0]  rem_q;
        logic [RT_W-1:0]   root_q;
        logic [SIDE_W-1:0] side_q;
        logic [REM_W-1:0]  cat;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  diff;
        logic              take;

        if (s == 0) begin : g_first
            assign vld_q  = in_vld;
            assign rad_q  = rad;
            assign rem_q  = '0;
            assign root_q = '0;
            assign side_q = side_in;
        end else begin : g_rest
            assign vld_q  = vld_reg[s-1];
            assign rad_q  = rad_reg[s-1];
            assign rem_q  = rem_reg[s-1];
            assign root_q = root_reg[s-1];
            assign side_q = side_reg[s-1];
        end

        // bring down two radicand bits, try root*4+1
        assign cat   = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
        assign trial = {root_q, 2'b01};
        assign take  = (cat >= trial);
        assign diff  = cat - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_q;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s]  <= {rad_q[RAD_W-3:0], 2'b00};
                rem_reg[s]  <= take ? diff : cat;
                root_reg[s] <= {root_q[RT_W-2:0], take};
                side_reg[s] <= side_q;
            end
        end
    end

    assign out_vld  = vld_reg[RT_W-1];
    assign root     = root_reg[RT_W-1];
    assign side_out = side_reg[RT_W-1];

endmodule
`default_nettype wire

/* rtl/rpc_div2.sv */
`default_nettype none
// rpc_div2: pipelined restoring divider, two dividends over one divisor,
// one quotient bit per stage, with sideband. Standalone.
module rpc_div2 #(
    parameter int NUM_W  = 43,
    parameter int DEN_W  = 32,
    parameter int Q_W    = 10,
    parameter int SIDE_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [NUM_W-1:0]  num_a,
    input  wire logic [NUM_W-1:0]  num_b,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_vld,
    output logic [Q_W-1:0]         q_a,
    output logic [Q_W-1:0]         q_b,
    output logic [SIDE_W-1:0]      side_out
);
    localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic              vld_reg  [Q_W];
    logic [NUM_W-1:0]  ra_reg   [Q_W];
    logic [NUM_W-1:0]  rb_reg   [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    qa_reg   [Q_W];
    logic [Q_W-1:0]    qb_reg   [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int K = Q_W - 1 - s;
        logic              vld_q;
        logic [NUM_W-1:0]  ra_q;
        logic [NUM_W-1:0]  rb_q;
        logic [DEN_W-1:0]  den_q;
        logic [Q_W-1:0]    qa_q;
        logic [Q_W-1:0]    qb_q;
        logic [SIDE_W-1:0] side_q;
        logic [CMP_W-1:0]  dsh;
        logic              take_a;
        logic              take_b;

        if (s == 0) begin : g_first
            assign vld_q  = in_vld;
            assign ra_q   = num_a;
            assign rb_q   = num_b;
            assign den_q  = den;
            assign qa_q   = '0;
            assign qb_q   = '0;
            assign side_q = side_in;
        end else begin : g_rest
            assign vld_q  = vld_reg[s-1];
            assign ra_q   = ra_reg[s-1];
            assign rb_q   = rb_reg[s-1];
            assign den_q  = den_reg[s-1];
            assign qa_q   = qa_reg[s-1];
            assign qb_q   = qb_reg[s-1];
            assign side_q = side_reg[s-1];
        end

        assign dsh    = CMP_W'(den_q) << K;
        assign take_a = (CMP_W'(ra_q) >= dsh);
        assign take_b = (CMP_W'(rb_q) >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_q;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ra_reg[s]   <= take_a ? NUM_W'(CMP_W'(ra_q) - dsh) : ra_q;
                rb_reg[s]   <= take_b ? NUM_W'(CMP_W'(rb_q) - dsh) : rb_q;
                den_reg[s]  <= den_q;
                qa_reg[s]   <= {qa_q[Q_W-2:0], take_a};
                qb_reg[s]   <= {qb_q[Q_W-2:0], take_b};
                side_reg[s] <= side_q;
            end
        end
    end

    assign out_vld  = vld_reg[Q_W-1];
    assign q_a      = qa_reg[Q_W-1];
    assign q_b      = qb_reg[Q_W-1];
    assign side_out = side_reg[Q_W-1];

endmodule
`default_nettype wire

/* rtl/radar_point_rotate_clamp.sv */
`default_nettype none
// radar_point_rotate_clamp: world point -> rotated radar pixel with radial clamp.
// Depends on rpc_pkg, rpc_if, rpc_isqrt and rpc_div2.
//
//  channel   dir   handshake      payload
//  -------   ---   ------------   ------------------------------------------
//  cfg       in    valid/ready    index (3b), data (24b); ready tied high
//  pt_in     in    valid/ready    target_x, target_z (24b signed, Q.FRAC_BITS)
//  pt_out    out   valid/ready    screen_x, screen_y (18b signed), was_clamped
//
//  Rate: one item per cycle while the skid entry is empty; pipe of 7 datapath stages,
//  32 square root stages, 10 divider stages and 1 output register.
//  Latency is set mostly by the one-bit-per-stage root and divide pipes.
//  Reset: rst_n async, clears valid bits and loads register reset values
//  (map_radius = 64, all others 0).
//  Stalls: the whole pipe moves on one enable; a two-entry output buffer
//  (output register plus skid) keeps pt_in.ready free of pt_out.ready.
module radar_point_rotate_clamp #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rpc_cfg_if.sink    cfg,
    rpc_in_if.sink     pt_in,
    rpc_out_if.source  pt_out
);
    import rpc_pkg::*;

    localparam int FP        = FRAC_BITS + 15;
    localparam int ANG_SHIFT = 16 - ANGLE_BITS;
    localparam logic [15:0] ANG_MASK = 16'((32'd1 << ANGLE_BITS) - 32'd1);

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] obs_x_reg;
    logic signed [COORD_W-1:0] obs_z_reg;
    logic [HEAD_W-1:0]         heading_reg;
    logic [CEN_W-1:0]          cen_x_reg;
    logic [CEN_W-1:0]          cen_y_reg;
    logic [RADIUS_W-1:0]       radius_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obs_x_reg   <= '0;
            obs_z_reg   <= '0;
            heading_reg <= '0;
            cen_x_reg   <= '0;
            cen_y_reg   <= '0;
            radius_reg  <= RADIUS_W'(64);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_OBSERVER_X:   obs_x_reg   <= $signed(cfg.data[COORD_W-1:0]);
                CFG_OBSERVER_Z:   obs_z_reg   <= $signed(cfg.data[COORD_W-1:0]);
                CFG_HEADING:      heading_reg <= cfg.data[HEAD_W-1:0];
                CFG_MAP_CENTER_X: cen_x_reg   <= cfg.data[CEN_W-1:0];
                CFG_MAP_CENTER_Y: cen_y_reg   <= cfg.data[CEN_W-1:0];
                CFG_MAP_RADIUS:   radius_reg  <= cfg.data[RADIUS_W-1:0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipe enable: everything advances unless the skid entry is occupied
    // ------------------------------------------------------------------
    logic skid_vld_reg;
    logic pipe_en;

    assign pipe_en     = !skid_vld_reg;
    assign pt_in.ready = pipe_en;

    // ------------------------------------------------------------------
    // S1: offsets from observer, trig from heading
    // cos = -sin(h), sin = -sin(h + quarter turn)
    // ------------------------------------------------------------------
    logic [15:0]              ang_cos;
    logic [15:0]              ang_sin;
    logic signed [TRIG_W-1:0] cos_c;
    logic signed [TRIG_W-1:0] sin_c;

    assign ang_cos = 16'({16'd0, heading_reg & ANG_MASK} << ANG_SHIFT);
    assign ang_sin = ang_cos + QUARTER_TURN;
    assign cos_c   = -sine_q15(ang_cos);
    assign sin_c   = -sine_q15(ang_sin);

    logic                     s1_vld_reg;
    logic signed [DIFF_W-1:0] s1_rx_reg;
    logic signed [DIFF_W-1:0] s1_rz_reg;
    logic signed [TRIG_W-1:0] s1_cos_reg;
    logic signed [TRIG_W-1:0] s1_sin_reg;

    // ------------------------------------------------------------------
    // S2: four rotation products
    // ------------------------------------------------------------------
    logic                     s2_vld_reg;
    logic signed [PROD_W-1:0] s2_xc_reg;
    logic signed [PROD_W-1:0] s2_zs_reg;
    logic signed [PROD_W-1:0] s2_xs_reg;
    logic signed [PROD_W-1:0] s2_zc_reg;

    // ------------------------------------------------------------------
    // S3: centre (fixed point) plus rotated offset, Y flipped
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] cxf_c;
    logic signed [SUM_W-1:0] cyf_c;
    logic signed [SUM_W-1:0] sumx_c;
    logic signed [SUM_W-1:0] sumy_c;

    assign cxf_c  = $signed(SUM_W'(cen_x_reg) << FP);
    assign cyf_c  = $signed(SUM_W'(cen_y_reg) << FP);
    assign sumx_c = cxf_c + SUM_W'(s2_xc_reg - s2_zs_reg);
    assign sumy_c = cyf_c - SUM_W'(s2_xs_reg + s2_zc_reg);

    logic                    s3_vld_reg;
    logic signed [SUM_W-1:0] s3_sumx_reg;
    logic signed [SUM_W-1:0] s3_sumy_reg;

    // ------------------------------------------------------------------
    // S4: truncate toward zero to whole pixels
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]        absx_c;
    logic [SUM_W-1:0]        absy_c;
    logic [SUM_W-1:0]        shx_c;
    logic [SUM_W-1:0]        shy_c;
    logic signed [PIX_W-1:0] px_c;
    logic signed [PIX_W-1:0] py_c;

    assign absx_c = s3_sumx_reg[SUM_W-1] ? SUM_W'(-s3_sumx_reg) : SUM_W'(s3_sumx_reg);
    assign absy_c = s3_sumy_reg[SUM_W-1] ? SUM_W'(-s3_sumy_reg) : SUM_W'(s3_sumy_reg);
    assign shx_c  = absx_c >> FP;
    assign shy_c  = absy_c >> FP;
    assign px_c   = s3_sumx_reg[SUM_W-1] ? -$signed(PIX_W'(shx_c)) : $signed(PIX_W'(shx_c));
    assign py_c   = s3_sumy_reg[SUM_W-1] ? -$signed(PIX_W'(shy_c)) : $signed(PIX_W'(shy_c));

    logic                    s4_vld_reg;
    logic signed [PIX_W-1:0] s4_px_reg;
    logic signed [PIX_W-1:0] s4_py_reg;

    // ------------------------------------------------------------------
    // S5: offset from centre
    // ------------------------------------------------------------------
    logic signed [PIX_W-1:0] cxp_c;
    logic signed [PIX_W-1:0] cyp_c;

    assign cxp_c = $signed(PIX_W'(cen_x_reg));
    assign cyp_c = $signed(PIX_W'(cen_y_reg));

    logic                    s5_vld_reg;
    logic signed [PIX_W-1:0] s5_px_reg;
    logic signed [PIX_W-1:0] s5_py_reg;
    logic signed [PIX_W-1:0] s5_dx_reg;
    logic signed [PIX_W-1:0] s5_dy_reg;

    // ------------------------------------------------------------------
    // S6: squares and magnitudes
    // ------------------------------------------------------------------
    logic signed [2*PIX_W-1:0] sqx_full;
    logic signed [2*PIX_W-1:0] sqy_full;
    logic signed [PIX_W-1:0]   ndx_c;
    logic signed [PIX_W-1:0]   ndy_c;

    assign sqx_full = (2*PIX_W)'(s5_dx_reg) * (2*PIX_W)'(s5_dx_reg);
    assign sqy_full = (2*PIX_W)'(s5_dy_reg) * (2*PIX_W)'(s5_dy_reg);
    assign ndx_c    = -s5_dx_reg;
    assign ndy_c    = -s5_dy_reg;

    logic                    s6_vld_reg;
    logic signed [PIX_W-1:0] s6_px_reg;
    logic signed [PIX_W-1:0] s6_py_reg;
    logic [D2_W-1:0]         s6_sqx_reg;
    logic [D2_W-1:0]         s6_sqy_reg;
    logic [MAG_W-1:0]        s6_magx_reg;
    logic [MAG_W-1:0]        s6_magy_reg;
    logic                    s6_negx_reg;
    logic                    s6_negy_reg;

    // ------------------------------------------------------------------
    // S7: distance squared, clamp decision, scaled numerators mag*r*64
    // ------------------------------------------------------------------
    logic [D2_W-1:0]         d2_c;
    logic [2*RADIUS_W-1:0]   r2_c;

    assign d2_c = s6_sqx_reg + s6_sqy_reg;
    assign r2_c = (2*RADIUS_W)'(radius_reg) * (2*RADIUS_W)'(radius_reg);

    logic       s7_vld_reg;
    logic [D2_W-1:0] s7_d2_reg;
    sq_side_t   s7_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_vld_reg <= pt_in.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_rx_reg  <= DIFF_W'(pt_in.target_x) - DIFF_W'(obs_x_reg);
            s1_rz_reg  <= DIFF_W'(pt_in.target_z) - DIFF_W'(obs_z_reg);
            s1_cos_reg <= cos_c;
            s1_sin_reg <= sin_c;

            s2_xc_reg <= PROD_W'(s1_rx_reg) * PROD_W'(s1_cos_reg);
            s2_zs_reg <= PROD_W'(s1_rz_reg) * PROD_W'(s1_sin_reg);
            s2_xs_reg <= PROD_W'(s1_rx_reg) * PROD_W'(s1_sin_reg);
            s2_zc_reg <= PROD_W'(s1_rz_reg) * PROD_W'(s1_cos_reg);

            s3_sumx_reg <= sumx_c;
            s3_sumy_reg <= sumy_c;

            s4_px_reg <= px_c;
            s4_py_reg <= py_c;

            s5_px_reg <= s4_px_reg;
            s5_py_reg <= s4_py_reg;
            s5_dx_reg <= s4_px_reg - cxp_c;
            s5_dy_reg <= s4_py_reg - cyp_c;

            s6_px_reg   <= s5_px_reg;
            s6_py_reg   <= s5_py_reg;
            s6_sqx_reg  <= sqx_full[D2_W-1:0];
            s6_sqy_reg  <= sqy_full[D2_W-1:0];
            s6_magx_reg <= s5_dx_reg[PIX_W-1] ? MAG_W'(ndx_c) : MAG_W'(s5_dx_reg);
            s6_magy_reg <= s5_dy_reg[PIX_W-1] ? MAG_W'(ndy_c) : MAG_W'(s5_dy_reg);
            s6_negx_reg <= s5_dx_reg[PIX_W-1];
            s6_negy_reg <= s5_dy_reg[PIX_W-1];

            s7_d2_reg         <= d2_c;
            s7_side_reg.px    <= s6_px_reg;
            s7_side_reg.py    <= s6_py_reg;
            s7_side_reg.neg_x <= s6_negx_reg;
            s7_side_reg.neg_y <= s6_negy_reg;
            // on the circle (d2 == r*r) stays put
            s7_side_reg.clamp <= (d2_c > D2_W'(r2_c));
            s7_side_reg.num_x <= (NUM_W'(s6_magx_reg) * NUM_W'(radius_reg)) << 6;
            s7_side_reg.num_y <= (NUM_W'(s6_magy_reg) * NUM_W'(radius_reg)) << 6;
        end
    end

    // ------------------------------------------------------------------
    // dist = floor(sqrt(d2 * 4096)), six fraction bits
    // ------------------------------------------------------------------
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    sq_side_t          sq_side;

    rpc_isqrt #(
        .RAD_W  (ISQ_W),
        .SIDE_W ($bits(sq_side_t))
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (s7_vld_reg),
        .rad      ({s7_d2_reg, {DIST_FRAC2{1'b0}}}),
        .side_in  (s7_side_reg),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .side_out (sq_side)
    );

    // ------------------------------------------------------------------
    // new offsets = mag*r*64 / dist; quotient never exceeds the radius
    // when clamping, so RADIUS_W quotient bits suffice
    // ------------------------------------------------------------------
    dv_side_t dv_side_in;
    dv_side_t dv_side;
    logic                dv_vld;
    logic [RADIUS_W-1:0] qx;
    logic [RADIUS_W-1:0] qy;

    assign dv_side_in.px    = sq_side.px;
    assign dv_side_in.py    = sq_side.py;
    assign dv_side_in.neg_x = sq_side.neg_x;
    assign dv_side_in.neg_y = sq_side.neg_y;
    assign dv_side_in.clamp = sq_side.clamp;

    rpc_div2 #(
        .NUM_W  (NUM_W),
        .DEN_W  (ROOT_W),
        .Q_W    (RADIUS_W),
        .SIDE_W ($bits(dv_side_t))
    ) u_div2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (sq_vld),
        .num_a    (sq_side.num_x),
        .num_b    (sq_side.num_y),
        .den      (sq_root),
        .side_in  (dv_side_in),
        .out_vld  (dv_vld),
        .q_a      (qx),
        .q_b      (qy),
        .side_out (dv_side)
    );

    // ------------------------------------------------------------------
    // final pixel: clamped point or original, saturated to 18 bits
    // ------------------------------------------------------------------
    function automatic logic [OUT_W-1:0] sat_pix(input logic signed [PIX_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (&v[PIX_W-1:OUT_W-1] || ~|v[PIX_W-1:OUT_W-1])
            r = v[OUT_W-1:0];
        else if (v[PIX_W-1])
            r = {1'b1, {(OUT_W-1){1'b0}}};
        else
            r = {1'b0, {(OUT_W-1){1'b1}}};
        return r;
    endfunction

    logic signed [PIX_W-1:0] qxs_c;
    logic signed [PIX_W-1:0] qys_c;
    logic signed [PIX_W-1:0] resx_c;
    logic signed [PIX_W-1:0] resy_c;
    logic [OUT_W-1:0]        outx_c;
    logic [OUT_W-1:0]        outy_c;

    assign qxs_c  = $signed(PIX_W'(qx));
    assign qys_c  = $signed(PIX_W'(qy));
    assign resx_c = dv_side.clamp ? cxp_c + (dv_side.neg_x ? -qxs_c : qxs_c) : dv_side.px;
    assign resy_c = dv_side.clamp ? cyp_c + (dv_side.neg_y ? -qys_c : qys_c) : dv_side.py;
    assign outx_c = sat_pix(resx_c);
    assign outy_c = sat_pix(resy_c);

    // ------------------------------------------------------------------
    // output register plus skid entry
    // ------------------------------------------------------------------
    logic             out_vld_reg;
    logic [OUT_W-1:0] out_x_reg;
    logic [OUT_W-1:0] out_y_reg;
    logic             out_c_reg;
    logic [OUT_W-1:0] skid_x_reg;
    logic [OUT_W-1:0] skid_y_reg;
    logic             skid_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || pt_out.ready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
                out_vld_reg <= dv_vld;
        end
        else if (dv_vld && !skid_vld_reg)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || pt_out.ready)
        begin
            if (skid_vld_reg)
            begin
                out_x_reg <= skid_x_reg;
                out_y_reg <= skid_y_reg;
                out_c_reg <= skid_c_reg;
            end
            else
            begin
                out_x_reg <= outx_c;
                out_y_reg <= outy_c;
                out_c_reg <= dv_side.clamp;
            end
        end
        else if (!skid_vld_reg)
        begin
            skid_x_reg <= outx_c;
            skid_y_reg <= outy_c;
            skid_c_reg <= dv_side.clamp;
        end
    end

    assign pt_out.valid       = out_vld_reg;
    assign pt_out.screen_x    = $signed(out_x_reg);
    assign pt_out.screen_y    = $signed(out_y_reg);
    assign pt_out.was_clamped = out_c_reg;

endmodule
`default_nettype wire
